// File: src/rms_pkg.sv
`default_nettype none
package rms_pkg;

  localparam int DEF_MAX_RECORDS = 64;
  localparam int DEF_NAME_BYTES  = 16;

  localparam int MOVE_W = 16;
  localparam int HALF_W = 64;
  localparam int REC_W  = MOVE_W + 2 * HALF_W;

  // Sequencer states of the sorter.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FETCH,
    ST_PRESENT
  } rms_state_t;

  // Mask that keeps the low nbytes bytes of a 64-bit name half.
  function automatic logic [HALF_W-1:0] name_mask(input int nbytes);
    logic [HALF_W-1:0] m;
    if (nbytes <= 0) begin
      m = '0;
    end else if (nbytes >= 8) begin
      m = '1;
    end else begin
      m = (HALF_W'(1) << (8 * nbytes)) - HALF_W'(1);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: src/record_merge_sorter_core.sv
// Loading: one record item per cycle, in_stall low in the load state, one store write each.
// Sorting: each output item takes a scan of n+2 cycles over the store plus 2 cycles to fetch
// and present the chosen record, so a batch of n records needs at least n*(n+4) cycles after
// the final item, more while the output is stalled. The single registered read port of the
// record store and the one key comparator set this.
// Reset (rst_n low, synchronous) empties the store count, clears the drop flag and the output.
`default_nettype none
module record_merge_sorter_core #(
  parameter int MAX_RECORDS = rms_pkg::DEF_MAX_RECORDS,
  parameter int NAME_BYTES  = rms_pkg::DEF_NAME_BYTES
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [rms_pkg::MOVE_W-1:0]   in_move_count,
  input  wire  [rms_pkg::HALF_W-1:0]   in_name_first_half,
  input  wire  [rms_pkg::HALF_W-1:0]   in_name_second_half,
  input  wire                          in_final_record,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [rms_pkg::MOVE_W-1:0]   out_sorted_moves,
  output logic [rms_pkg::HALF_W-1:0]   out_sorted_name_first,
  output logic [rms_pkg::HALF_W-1:0]   out_sorted_name_second,
  output logic                         out_last_out,
  output logic                         out_overflow_flag
);
  import rms_pkg::*;

  // Address and count widths. The count must be able to hold MAX_RECORDS itself.
  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  // Sort key: move count above the inverted store index. Loads prepend to the list,
  // so a later store index comes first among equal counts, which the inversion gives.
  localparam int KW = MOVE_W + AW;

  localparam logic [HALF_W-1:0] MASK_LO = name_mask(NAME_BYTES);
  localparam logic [HALF_W-1:0] MASK_HI = name_mask(NAME_BYTES - 8);
  localparam logic [CW-1:0]     CAP     = CW'(MAX_RECORDS);

  // Record store, one entry per loaded record: {second half, first half, moves}.
  logic [REC_W-1:0] mem [MAX_RECORDS];
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REC_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [REC_W-1:0] rd_data_r;

  rms_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;        // records held in the store
  logic          drop_r, drop_nxt;      // some load of this batch was dropped
  logic [CW-1:0] total_r, total_nxt;    // batch size being sorted
  logic [CW-1:0] emit_r, emit_nxt;      // records already handed to the output
  logic [CW-1:0] issue_r, issue_nxt;    // next store address the scan reads
  logic          pv_r, pv_nxt;          // rd_data_r holds a scanned entry
  logic [AW-1:0] pidx_r, pidx_nxt;      // index of that entry
  logic          first_r, first_nxt;    // nothing emitted yet in this batch
  logic [KW-1:0] prev_key_r, prev_key_nxt;
  logic          found_r, found_nxt;
  logic [KW-1:0] best_key_r, best_key_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_ld;
  logic          is_last;
  logic [KW-1:0] cand_key;
  logic          gt_prev, lt_best;
  logic          has_room;

  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = {in_name_second_half & MASK_HI, in_name_first_half & MASK_LO, in_move_count};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // The shared comparator: each scanned entry is checked against the last emitted key
  // and against the best candidate so far. The next output is the smallest key above
  // the previous one.
  assign cand_key = {rd_data_r[MOVE_W-1:0], ~pidx_r};
  assign gt_prev  = first_r || (cand_key > prev_key_r);
  assign lt_best  = !found_r || (cand_key < best_key_r);
  assign has_room = cnt_r < CAP;
  assign is_last  = (emit_r + CW'(1)) == total_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    drop_nxt     = drop_r;
    total_nxt    = total_r;
    emit_nxt     = emit_r;
    issue_nxt    = issue_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    first_nxt    = first_r;
    prev_key_nxt = prev_key_r;
    found_nxt    = found_r;
    best_key_nxt = best_key_r;
    wr_en        = 1'b0;
    rd_addr      = issue_r[AW-1:0];
    in_stall     = 1'b1;
    out_ld       = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (has_room) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_final_record) begin
            // A dropped final item still starts the sort over what the store holds.
            total_nxt = has_room ? cnt_r + CW'(1) : cnt_r;
            emit_nxt  = '0;
            issue_nxt = '0;
            first_nxt = 1'b1;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (issue_r < total_r) begin
          pv_nxt    = 1'b1;
          pidx_nxt  = issue_r[AW-1:0];
          issue_nxt = issue_r + CW'(1);
        end
        if (pv_r && gt_prev && lt_best) begin
          found_nxt    = 1'b1;
          best_key_nxt = cand_key;
        end
        if ((issue_r == total_r) && !pv_r) begin
          state_nxt = ST_FETCH;
        end
      end

      ST_FETCH: begin
        rd_addr   = ~best_key_r[AW-1:0];
        state_nxt = ST_PRESENT;
      end

      ST_PRESENT: begin
        // Hold the read address so the fetched record stays put while the output is busy.
        rd_addr = ~best_key_r[AW-1:0];
        if (!out_valid_r || !out_stall) begin
          out_ld       = 1'b1;
          prev_key_nxt = best_key_r;
          first_nxt    = 1'b0;
          emit_nxt     = emit_r + CW'(1);
          if (is_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            issue_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid_nxt = out_ld || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    emit_r     <= emit_nxt;
    issue_r    <= issue_nxt;
    pidx_r     <= pidx_nxt;
    first_r    <= first_nxt;
    prev_key_r <= prev_key_nxt;
    found_r    <= found_nxt;
    best_key_r <= best_key_nxt;
    if (out_ld) begin
      out_sorted_moves       <= rd_data_r[MOVE_W-1:0];
      out_sorted_name_first  <= rd_data_r[MOVE_W +: HALF_W];
      out_sorted_name_second <= rd_data_r[MOVE_W + HALF_W +: HALF_W];
      out_last_out           <= is_last;
      out_overflow_flag      <= drop_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/rms_checker.sv
`default_nettype none
module rms_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire                        in_final_record,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire [rms_pkg::MOVE_W-1:0]  out_sorted_moves,
  input wire [rms_pkg::HALF_W-1:0]  out_sorted_name_first,
  input wire [rms_pkg::HALF_W-1:0]  out_sorted_name_second,
  input wire                        out_last_out,
  input wire                        out_overflow_flag
);

  // A held output item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_moves)
      && $stable(out_sorted_name_first) && $stable(out_sorted_name_second)
      && $stable(out_last_out) && $stable(out_overflow_flag))
    else $error("output item changed while stalled");

  // Reset leaves no output item pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // While a batch is still being emitted, no new record is taken.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_out |-> in_stall)
    else $error("input taken during sort");

  // A record that is not final keeps the block loading.
  a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_final_record |=> !in_stall)
    else $error("block left loading without a final record");

endmodule

bind record_merge_sorter_core rms_checker u_rms_checker (.*);
`default_nettype wire
